[rtl/core/srsw_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the selective-repeat send window.
// No dependencies; the controller, datapath and top use these by scoped name, the checker and testbench import them.
package srsw_pkg;

  // Operation codes carried by the operation field of an input item.
  typedef enum logic [2:0] {
    OP_RESTART   = 3'd0,
    OP_TAKE      = 3'd1,
    OP_TIMEOUT   = 3'd2,
    OP_SENT      = 3'd3,
    OP_ACKED     = 3'd4,
    OP_FAIL      = 3'd5,
    OP_CANCEL    = 3'd6,
    OP_SET_STATE = 3'd7
  } op_t;

  // Session states.
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_SENDING   = 3'd1,
    ST_WAITING   = 3'd2,
    ST_COMPLETED = 3'd3,
    ST_FAILED    = 3'd4,
    ST_CANCELED  = 3'd5
  } sess_t;

  localparam logic [2:0] ST_LAST_CODE = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_TOTAL    = 2'd0;
  localparam logic [1:0] REG_MAX_FLT  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;
  localparam logic [1:0] REG_MAX_ATT  = 2'd3;

  localparam logic [7:0] ATT_MAX = 8'd255;

  // Controller states.
  typedef enum logic [2:0] {
    F_INIT,
    F_IDLE,
    F_SWEEP,
    F_SCAN,
    F_LOOKUP,
    F_APPLY,
    F_PREP,
    F_EMIT
  } fsm_t;

  // Configuration register values.
  typedef struct packed {
    logic [10:0] total_chunks;
    logic [6:0]  max_in_flight;
    logic [31:0] timeout_ms;
    logic [7:0]  max_attempts;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sweep;
    logic scan;
    logic lookup;
    logic apply;
    logic emit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;
    logic scan_done;
    logic emit_last;
  } sts_t;

endpackage

[rtl/core/srsw_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/srsw_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the send window: sequences sweep, scan,
// lookup, apply and emit phases. Depends on srsw_pkg.
module srsw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          operation,
  input  srsw_pkg::sts_t      sts,
  output srsw_pkg::ctl_t      ctl,
  output logic                busy
);

  srsw_pkg::fsm_t state, state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srsw_pkg::F_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    case (state)
      srsw_pkg::F_INIT: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_done) state_next = srsw_pkg::F_IDLE;
      end
      srsw_pkg::F_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load = 1'b1;
          case (srsw_pkg::op_t'(operation))
            srsw_pkg::OP_RESTART, srsw_pkg::OP_CANCEL: state_next = srsw_pkg::F_SWEEP;
            srsw_pkg::OP_TAKE, srsw_pkg::OP_TIMEOUT:   state_next = srsw_pkg::F_SCAN;
            srsw_pkg::OP_SENT, srsw_pkg::OP_ACKED:     state_next = srsw_pkg::F_LOOKUP;
            default:                                   state_next = srsw_pkg::F_PREP;
          endcase
        end
      end
      srsw_pkg::F_SWEEP: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_done) state_next = srsw_pkg::F_PREP;
      end
      srsw_pkg::F_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) state_next = srsw_pkg::F_PREP;
      end
      srsw_pkg::F_LOOKUP: begin
        ctl.lookup = 1'b1;
        state_next = srsw_pkg::F_APPLY;
      end
      srsw_pkg::F_APPLY: begin
        ctl.apply  = 1'b1;
        state_next = srsw_pkg::F_PREP;
      end
      srsw_pkg::F_PREP: begin
        state_next = srsw_pkg::F_EMIT;
      end
      srsw_pkg::F_EMIT: begin
        ctl.emit = 1'b1;
        if (sts.emit_last) state_next = srsw_pkg::F_IDLE;
      end
      default: begin
        state_next = srsw_pkg::F_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/srsw_dp.sv]
`timescale 1ns / 1ps
// Datapath of the send window: chunk maps, attempt/time store, emit list,
// session counters. Depends on srsw_pkg and srsw_ram.
module srsw_dp #(
  parameter int MAX_CHUNKS   = 1024,
  parameter int FLIGHT_LIMIT = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  srsw_pkg::ctl_t   ctl,
  output srsw_pkg::sts_t   sts,
  input  srsw_pkg::cfg_t   cfg,
  input  logic [2:0]       operation,
  input  logic [9:0]       chunk_index,
  input  logic [31:0]      now_ms,
  input  logic [2:0]       new_state,
  output logic             chunk_valid,
  output logic [9:0]       chunk_out,
  output logic             last,
  output logic             accepted,
  output logic [2:0]       session_state,
  output logic [10:0]      acked_count,
  output logic [6:0]       in_flight_count,
  output logic             complete
);

  localparam int CW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int BW    = (CNT_W > 11) ? CNT_W : 11;
  localparam int LW    = (FLIGHT_LIMIT > 1) ? $clog2(FLIGHT_LIMIT) : 1;
  localparam int TW    = 40;

  // Latched item and session registers.
  srsw_pkg::op_t   op_q;
  logic [9:0]      idx_q;
  logic [31:0]     now_q;
  srsw_pkg::sess_t mode;
  logic [10:0]     acked_total;
  logic [6:0]      flight_total;
  logic            acc;

  // Walk counters.
  logic [BW-1:0]   ra;
  logic [BW-1:0]   pj;
  logic            pv;
  logic [6:0]      n;
  logic [6:0]      e;

  // Memory ports.
  logic            fl_we, ak_we, at_we;
  logic [CW-1:0]   fl_waddr, ak_waddr, rd_addr;
  logic            fl_wdata, ak_wdata;
  logic [TW-1:0]   at_wdata;
  logic            fl_rd, ak_rd;
  logic [TW-1:0]   at_rd;
  logic            ls_we;
  logic [LW-1:0]   ls_waddr, ls_raddr;
  logic [9:0]      ls_rd;

  // Derived values.
  logic [BW-1:0]   eff_total;
  logic            is_done_now;
  logic            is_take;
  logic            active;
  logic [6:0]      lim;
  logic [BW-1:0]   bound;
  logic            full;
  logic            hit;
  logic            issue;
  logic            scan_done;
  logic            idx_ok;
  logic            sent_ok;
  logic            ack_ok;
  logic [7:0]      att_old;
  logic [7:0]      att_new;
  logic [31:0]     age;

  // Effective totals and completion.
  assign eff_total   = (BW'(cfg.total_chunks) > BW'(MAX_CHUNKS)) ? BW'(MAX_CHUNKS)
                                                               : BW'(cfg.total_chunks);
  assign is_done_now = (eff_total != '0) && (BW'(acked_total) >= eff_total);

  // Scan control for take window and timeout scan.
  assign is_take = (op_q == srsw_pkg::OP_TAKE);
  assign active  = !is_take || (mode == srsw_pkg::ST_SENDING) ||
                   (mode == srsw_pkg::ST_WAITING);
  assign lim     = (cfg.max_in_flight > 7'(FLIGHT_LIMIT)) ? 7'(FLIGHT_LIMIT)
                                                          : cfg.max_in_flight;
  assign bound   = is_take ? eff_total : BW'(MAX_CHUNKS);
  assign full    = is_take ? (flight_total >= lim) : (n >= 7'(FLIGHT_LIMIT));
  assign age     = now_q - at_rd[31:0];
  assign scan_done = !active || full || ((ra >= bound) && !pv);
  assign hit = pv && !full && active &&
               (is_take ? (!ak_rd && !fl_rd)
                        : (fl_rd && (at_rd[39:32] < cfg.max_attempts) &&
                           (age >= cfg.timeout_ms)));
  assign issue = ctl.scan && !scan_done && (ra < bound);

  // Single-entry checks for mark sent and mark acked.
  assign idx_ok  = (32'(idx_q) < 32'(MAX_CHUNKS));
  assign sent_ok = idx_ok && (fl_rd || (flight_total < 7'(FLIGHT_LIMIT)));
  assign ack_ok  = idx_ok && (BW'(idx_q) < eff_total) && !ak_rd;
  assign att_old = fl_rd ? at_rd[39:32] : 8'd0;
  assign att_new = (att_old == srsw_pkg::ATT_MAX) ? att_old : att_old + 8'd1;

  // Read address: the walk counter while scanning, else the item's chunk.
  assign rd_addr = ctl.scan ? CW'(ra) : CW'(idx_q);

  // Write port selection for the three chunk stores.
  always_comb begin
    fl_we    = 1'b0;
    fl_waddr = CW'(idx_q);
    fl_wdata = 1'b0;
    ak_we    = 1'b0;
    ak_waddr = CW'(idx_q);
    ak_wdata = 1'b1;
    at_we    = 1'b0;
    at_wdata = {att_new, now_q};
    if (ctl.sweep) begin
      fl_we    = 1'b1;
      fl_waddr = CW'(ra);
      ak_we    = (op_q == srsw_pkg::OP_RESTART);
      ak_waddr = CW'(ra);
      ak_wdata = 1'b0;
    end else if (ctl.scan) begin
      fl_we    = hit && is_take;
      fl_waddr = CW'(pj);
      fl_wdata = 1'b1;
      at_we    = hit && is_take;
      at_wdata = '0;
    end else if (ctl.apply) begin
      if (op_q == srsw_pkg::OP_SENT) begin
        fl_we    = sent_ok;
        fl_wdata = 1'b1;
        at_we    = sent_ok;
      end else begin
        fl_we    = ack_ok && fl_rd;
        fl_wdata = 1'b0;
        ak_we    = ack_ok;
      end
    end
  end

  assign ls_we    = ctl.scan && hit;
  assign ls_waddr = LW'(n);
  assign ls_raddr = ctl.emit ? LW'(e + 7'd1) : '0;

  srsw_ram #(.WIDTH(1), .DEPTH(MAX_CHUNKS)) u_flight (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(rd_addr), .rdata(fl_rd)
  );

  srsw_ram #(.WIDTH(1), .DEPTH(MAX_CHUNKS)) u_acked (
    .clk(clk), .we(ak_we), .waddr(ak_waddr), .wdata(ak_wdata),
    .raddr(rd_addr), .rdata(ak_rd)
  );

  srsw_ram #(.WIDTH(TW), .DEPTH(MAX_CHUNKS)) u_attime (
    .clk(clk), .we(at_we), .waddr(fl_waddr), .wdata(at_wdata),
    .raddr(rd_addr), .rdata(at_rd)
  );

  srsw_ram #(.WIDTH(10), .DEPTH(FLIGHT_LIMIT)) u_list (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(10'(pj)),
    .raddr(ls_raddr), .rdata(ls_rd)
  );

  // Item latch (payload, no reset).
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      idx_q <= chunk_index;
      now_q <= now_ms;
    end
    if (ctl.scan) begin
      pj <= ra;
    end
  end

  // Session state, counters and walk control.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_q         <= srsw_pkg::OP_RESTART;
      mode         <= srsw_pkg::ST_IDLE;
      acked_total  <= '0;
      flight_total <= '0;
      acc          <= 1'b0;
      ra           <= '0;
      pv           <= 1'b0;
      n            <= '0;
      e            <= '0;
    end else begin
      if (ctl.load) begin
        op_q <= srsw_pkg::op_t'(operation);
        acc  <= 1'b0;
        ra   <= '0;
        pv   <= 1'b0;
        n    <= '0;
        e    <= '0;
        case (srsw_pkg::op_t'(operation))
          srsw_pkg::OP_RESTART: begin
            acked_total  <= '0;
            flight_total <= '0;
            mode         <= srsw_pkg::ST_SENDING;
          end
          srsw_pkg::OP_FAIL: begin
            mode <= srsw_pkg::ST_FAILED;
          end
          srsw_pkg::OP_CANCEL: begin
            flight_total <= '0;
            mode         <= srsw_pkg::ST_CANCELED;
          end
          srsw_pkg::OP_SET_STATE: begin
            if (new_state <= srsw_pkg::ST_LAST_CODE) mode <= srsw_pkg::sess_t'(new_state);
          end
          default: begin
          end
        endcase
      end
      // Clearing pass walks every entry once.
      if (ctl.sweep) begin
        ra <= ra + BW'(1);
      end
      // Pipelined walk: read one entry per cycle, judge the previous one.
      if (ctl.scan) begin
        pv <= issue;
        if (issue) ra <= ra + BW'(1);
        if (hit) begin
          n <= n + 7'd1;
          if (is_take) flight_total <= flight_total + 7'd1;
        end
        if (scan_done && is_take && active && (n == '0) && !is_done_now) begin
          mode <= srsw_pkg::ST_WAITING;
        end
      end
      // Mark sent and mark acked take effect with the entry in hand.
      if (ctl.apply) begin
        if (op_q == srsw_pkg::OP_SENT) begin
          if (sent_ok) begin
            acc <= 1'b1;
            if (!fl_rd) flight_total <= flight_total + 7'd1;
            if (mode == srsw_pkg::ST_IDLE) mode <= srsw_pkg::ST_SENDING;
          end
        end else if (ack_ok) begin
          acc         <= 1'b1;
          acked_total <= acked_total + 11'd1;
          if (fl_rd) flight_total <= flight_total - 7'd1;
          if ((eff_total != '0) && (BW'(acked_total + 11'd1) >= eff_total)) begin
            mode <= srsw_pkg::ST_COMPLETED;
          end else begin
            mode <= srsw_pkg::ST_SENDING;
          end
        end
      end
      if (ctl.emit) begin
        e <= e + 7'd1;
      end
    end
  end

  // Status back to the controller.
  assign sts.sweep_done = (ra == BW'(MAX_CHUNKS - 1));
  assign sts.scan_done  = scan_done;
  assign sts.emit_last  = last;

  // Result fields.
  assign chunk_valid     = (n != '0);
  assign chunk_out       = (n != '0) ? ls_rd : '0;
  assign last            = (n == '0) || ((e + 7'd1) == n);
  assign accepted        = acc;
  assign session_state   = mode;
  assign acked_count     = acked_total;
  assign in_flight_count = flight_total;
  assign complete        = is_done_now;

endmodule

[rtl/core/selective_repeat_send_window.sv]
`timescale 1ns / 1ps
// Selective-repeat send window, top level: APB register file, controller, datapath.
// Restart and cancel sweep the flight map (restart also the acked map), then give one result.
// Take window walks up to min(total, MAX_CHUNKS) chunks, timeout scan up to MAX_CHUNKS;
// both walk one chunk a cycle, then emit their result items.
// Mark sent and mark acked pass through lookup and apply states; results cannot be stalled.
// After reset, busy stays high while the chunk maps are cleared.
module selective_repeat_send_window #(
  parameter int MAX_CHUNKS   = 1024,
  parameter int FLIGHT_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [9:0]  chunk_index,
  input  logic [31:0] now_ms,
  input  logic [2:0]  new_state,
  output logic        strobe,
  output logic        chunk_valid,
  output logic [9:0]  chunk_out,
  output logic        last,
  output logic        accepted,
  output logic [2:0]  session_state,
  output logic [10:0] acked_count,
  output logic [6:0]  in_flight_count,
  output logic        complete,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  srsw_pkg::cfg_t cfg;
  srsw_pkg::ctl_t ctl;
  srsw_pkg::sts_t sts;
  logic           wr_en;

  // Register writes complete in the access cycle.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_chunks  <= 11'd0;
      cfg.max_in_flight <= 7'd8;
      cfg.timeout_ms    <= 32'd1000;
      cfg.max_attempts  <= 8'd5;
    end else if (wr_en) begin
      case (paddr[3:2])
        srsw_pkg::REG_TOTAL:   cfg.total_chunks  <= pwdata[10:0];
        srsw_pkg::REG_MAX_FLT: cfg.max_in_flight <= pwdata[6:0];
        srsw_pkg::REG_TIMEOUT: cfg.timeout_ms    <= pwdata;
        srsw_pkg::REG_MAX_ATT: cfg.max_attempts  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      srsw_pkg::REG_TOTAL:   prdata = {21'd0, cfg.total_chunks};
      srsw_pkg::REG_MAX_FLT: prdata = {25'd0, cfg.max_in_flight};
      srsw_pkg::REG_TIMEOUT: prdata = cfg.timeout_ms;
      srsw_pkg::REG_MAX_ATT: prdata = {24'd0, cfg.max_attempts};
      default:               prdata = '0;
    endcase
  end

  // Each result item is shown for one cycle during the emit phase.
  assign strobe = ctl.emit;

  srsw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .sts(sts), .ctl(ctl), .busy(busy)
  );

  srsw_dp #(.MAX_CHUNKS(MAX_CHUNKS), .FLIGHT_LIMIT(FLIGHT_LIMIT)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .cfg(cfg),
    .operation(operation), .chunk_index(chunk_index), .now_ms(now_ms),
    .new_state(new_state), .chunk_valid(chunk_valid), .chunk_out(chunk_out),
    .last(last), .accepted(accepted), .session_state(session_state),
    .acked_count(acked_count), .in_flight_count(in_flight_count),
    .complete(complete)
  );

endmodule

[sim/srsw_checker.sv]
`timescale 1ns / 1ps
// Checker for the selective-repeat send window: watches the command, result and APB channels,
// predicts every result item and compares it field by field. Depends on srsw_pkg.
module srsw_checker
  import srsw_pkg::*;
#(
  parameter int MAX_CHUNKS   = 1024,
  parameter int FLIGHT_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  operation,
  input  logic [9:0]  chunk_index,
  input  logic [31:0] now_ms,
  input  logic [2:0]  new_state,
  input  logic        strobe,
  input  logic        chunk_valid,
  input  logic [9:0]  chunk_out,
  input  logic        last,
  input  logic        accepted,
  input  logic [2:0]  session_state,
  input  logic [10:0] acked_count,
  input  logic [6:0]  in_flight_count,
  input  logic        complete,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          items_seen,
  output int          results_seen
);

  typedef struct packed {
    logic        cv;
    logic [9:0]  chunk;
    logic        lst;
    logic        acc;
    logic [2:0]  sess;
    logic [10:0] n_ack;
    logic [6:0]  n_fly;
    logic        done;
  } window_res_t;

  window_res_t expected_q[$];

  // Shadow copy of the window state and the registers.
  bit          acked_bits [MAX_CHUNKS];
  bit          flying     [MAX_CHUNKS];
  logic [7:0]  tries      [MAX_CHUNKS];
  logic [31:0] sent_at    [MAX_CHUNKS];
  sess_t       mode;
  logic [10:0] n_acked;
  logic [6:0]  n_flying;
  logic [10:0] cfg_total;
  logic [6:0]  cfg_window;
  logic [31:0] cfg_timeout;
  logic [7:0]  cfg_attempts;

  function automatic int span();
    return (cfg_total > MAX_CHUNKS) ? MAX_CHUNKS : int'(cfg_total);
  endfunction

  function automatic bit all_acked();
    return span() > 0 && int'(n_acked) >= span();
  endfunction

  function automatic void push_status(bit cv, logic [9:0] chunk, bit acc);
    window_res_t r;
    r.cv    = cv;
    r.chunk = cv ? chunk : 10'd0;
    r.lst   = 1'b0;
    r.acc   = acc;
    r.sess  = mode;
    r.n_ack = n_acked;
    r.n_fly = n_flying;
    r.done  = all_acked();
    expected_q.push_back(r);
  endfunction

  // Applies one accepted item to the shadow state and queues its results.
  function automatic void predict_window(op_t op, logic [9:0] idx, logic [31:0] now,
                                         logic [2:0] ns);
    int list[$];
    int lim;
    bit acc;
    acc = 1'b0;
    case (op)
      OP_RESTART: begin
        foreach (acked_bits[i]) begin
          acked_bits[i] = 1'b0;
          flying[i] = 1'b0;
        end
        n_flying = '0;
        n_acked = '0;
        mode = ST_SENDING;
      end
      OP_TAKE: begin
        if (mode == ST_SENDING || mode == ST_WAITING) begin
          lim = (cfg_window > FLIGHT_LIMIT) ? FLIGHT_LIMIT : int'(cfg_window);
          for (int i = 0; i < span() && int'(n_flying) < lim; i++) begin
            if (!acked_bits[i] && !flying[i]) begin
              flying[i] = 1'b1;
              tries[i] = 8'd0;
              sent_at[i] = 32'd0;
              n_flying++;
              list.push_back(i);
            end
          end
          if (list.size() == 0 && !all_acked()) mode = ST_WAITING;
        end
      end
      OP_TIMEOUT: begin
        for (int i = 0; i < MAX_CHUNKS && list.size() < FLIGHT_LIMIT; i++) begin
          if (flying[i] && tries[i] < cfg_attempts && (now - sent_at[i]) >= cfg_timeout)
            list.push_back(i);
        end
      end
      OP_SENT: begin
        if (int'(idx) < MAX_CHUNKS && (flying[idx] || n_flying < FLIGHT_LIMIT)) begin
          if (!flying[idx]) begin
            flying[idx] = 1'b1;
            tries[idx] = 8'd0;
            n_flying++;
          end
          if (tries[idx] != ATT_MAX) tries[idx]++;
          sent_at[idx] = now;
          if (mode == ST_IDLE) mode = ST_SENDING;
          acc = 1'b1;
        end
      end
      OP_ACKED: begin
        if (int'(idx) < span() && !acked_bits[idx]) begin
          if (flying[idx]) begin
            flying[idx] = 1'b0;
            n_flying--;
          end
          acked_bits[idx] = 1'b1;
          n_acked++;
          mode = all_acked() ? ST_COMPLETED : ST_SENDING;
          acc = 1'b1;
        end
      end
      OP_FAIL: mode = ST_FAILED;
      OP_CANCEL: begin
        mode = ST_CANCELED;
        foreach (flying[i]) flying[i] = 1'b0;
        n_flying = '0;
      end
      default: begin
        if (ns <= ST_LAST_CODE) mode = sess_t'(ns);
      end
    endcase
    // Status fields reflect the state after the whole step.
    if (list.size() == 0) push_status(1'b0, 10'd0, acc);
    foreach (list[k]) push_status(1'b1, 10'(list[k]), 1'b0);
    expected_q[expected_q.size() - 1].lst = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    items_seen = 0;
    results_seen = 0;
  end

  assign pending = expected_q.size();

  // Sample every channel at the rising edge, before the block's outputs move on.
  always @(posedge clk) begin
    window_res_t w;
    if (rst) begin
      foreach (acked_bits[i]) begin
        acked_bits[i] = 1'b0;
        flying[i] = 1'b0;
      end
      mode = ST_IDLE;
      n_acked = '0;
      n_flying = '0;
      cfg_total = 11'd0;
      cfg_window = 7'd8;
      cfg_timeout = 32'd1000;
      cfg_attempts = 8'd5;
      expected_q.delete();
    end else begin
      if (strobe) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result item with no expectation waiting (chunk_out %0d)", chunk_out);
          fail_count++;
        end else begin
          w = expected_q.pop_front();
          check_field("chunk_valid", w.cv, chunk_valid);
          check_field("chunk_out", w.chunk, chunk_out);
          check_field("last", w.lst, last);
          check_field("accepted", w.acc, accepted);
          check_field("session_state", w.sess, session_state);
          check_field("acked_count", w.n_ack, acked_count);
          check_field("in_flight_count", w.n_fly, in_flight_count);
          check_field("complete", w.done, complete);
        end
      end
      if (start && !busy) begin
        items_seen++;
        predict_window(op_t'(operation), chunk_index, now_ms, new_state);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_TOTAL:   cfg_total = pwdata[10:0];
          REG_MAX_FLT: cfg_window = pwdata[6:0];
          REG_TIMEOUT: cfg_timeout = pwdata;
          REG_MAX_ATT: cfg_attempts = pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the selective-repeat send window: clock, reset, directed and random
// command items, APB register phases and the verdict. Depends on srsw_pkg and srsw_checker.
module tb;
  import srsw_pkg::*;

  localparam int STALL_LIMIT = 12000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  operation;
  logic [9:0]  chunk_index;
  logic [31:0] now_ms;
  logic [2:0]  new_state;
  logic        strobe;
  logic        chunk_valid;
  logic [9:0]  chunk_out;
  logic        last;
  logic        accepted;
  logic [2:0]  session_state;
  logic [10:0] acked_count;
  logic [6:0]  in_flight_count;
  logic        complete;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          items_seen;
  int          results_seen;
  int          idle_pct;
  int          stall_cycles;
  int          cur_total;
  logic [31:0] clock_ms;

  selective_repeat_send_window u_top (.*);

  srsw_checker u_chk (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: cycles with neither an accepted item nor a result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("selective_repeat_send_window verification failed");
      $finish;
    end
  end

  // Presents one item and returns at the edge at which it is accepted.
  task automatic issue(op_t op, logic [9:0] idx, logic [31:0] now, logic [2:0] ns);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    chunk_index <= idx;
    now_ms <= now;
    new_state <= ns;
    do @(posedge clk); while (busy);
  endtask

  // Holds off until every expected result item has come and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_TOTAL) cur_total = value[10:0];
  endtask

  task automatic configure(int total, int window, logic [31:0] tmo, int att);
    write_reg(REG_TOTAL, total);
    write_reg(REG_MAX_FLT, window);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_MAX_ATT, att);
  endtask

  // Mostly chunks near the transfer, sometimes anywhere in the index range.
  function automatic logic [9:0] pick_chunk();
    int hi;
    hi = (cur_total > 1022) ? 1023 : cur_total + 1;
    return ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, hi)) : 10'($urandom);
  endfunction

  // One random item: mostly a live transfer with advancing time, plus noise.
  task automatic random_item();
    int roll;
    op_t op;
    roll = $urandom_range(0, 99);
    if (roll < 4) op = OP_RESTART;
    else if (roll < 24) op = OP_TAKE;
    else if (roll < 38) op = OP_TIMEOUT;
    else if (roll < 62) op = OP_SENT;
    else if (roll < 88) op = OP_ACKED;
    else if (roll < 91) op = OP_FAIL;
    else if (roll < 94) op = OP_CANCEL;
    else op = OP_SET_STATE;
    clock_ms += $urandom_range(0, 400);
    if ($urandom_range(0, 99) < 5) clock_ms = $urandom;
    issue(op, pick_chunk(), clock_ms, 3'($urandom_range(0, 7)));
  endtask

  initial begin
    int phase_total [6] = '{12, 40, 0, 2047, 1024, 20};
    int phase_win   [6] = '{4, 64, 1, 127, 8, 16};
    int phase_att   [6] = '{3, 255, 1, 5, 2, 6};
    logic [31:0] phase_tmo [6] = '{32'd300, 32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd500, 32'd200};
    rst = 1'b1;
    start = 1'b0;
    operation = OP_RESTART;
    chunk_index = '0;
    now_ms = '0;
    new_state = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    stall_cycles = 0;
    cur_total = 0;
    clock_ms = 32'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: window fill, expiry, acks, refusals and state control.
    configure(10, 4, 32'd1000, 5);
    issue(OP_TAKE, 10'd0, 32'd0, ST_IDLE);
    issue(OP_RESTART, 10'd0, 32'd0, ST_IDLE);
    issue(OP_TAKE, 10'd0, 32'd0, ST_IDLE);
    issue(OP_TAKE, 10'd0, 32'd0, ST_IDLE);
    issue(OP_TIMEOUT, 10'd0, 32'd999, ST_IDLE);
    issue(OP_TIMEOUT, 10'd0, 32'hFFFF_FFFF, ST_IDLE);
    issue(OP_SENT, 10'd0, 32'hFFFF_FF00, ST_IDLE);
    issue(OP_TIMEOUT, 10'd0, 32'd1000, ST_IDLE);
    issue(OP_ACKED, 10'd0, 32'd0, ST_IDLE);
    issue(OP_ACKED, 10'd0, 32'd0, ST_IDLE);
    issue(OP_ACKED, 10'd1023, 32'd0, ST_IDLE);
    issue(OP_SENT, 10'd0, 32'd5, ST_IDLE);
    issue(OP_SET_STATE, 10'd0, 32'd0, 3'd6);
    issue(OP_SET_STATE, 10'd0, 32'd0, 3'd7);
    issue(OP_SET_STATE, 10'd0, 32'd0, ST_IDLE);
    issue(OP_SENT, 10'd1023, 32'd7, ST_IDLE);
    issue(OP_FAIL, 10'd0, 32'd0, ST_IDLE);
    issue(OP_CANCEL, 10'd0, 32'd0, ST_IDLE);
    issue(OP_TAKE, 10'd0, 32'd0, ST_IDLE);
    // Full table: a window clamped to 64 fills up, then a new chunk is refused.
    configure(1024, 127, 32'd0, 255);
    issue(OP_RESTART, 10'd0, 32'd0, ST_IDLE);
    issue(OP_TAKE, 10'd0, 32'd0, ST_IDLE);
    issue(OP_SENT, 10'd700, 32'd0, ST_IDLE);
    issue(OP_TIMEOUT, 10'd0, 32'd0, ST_IDLE);
    // Attempt count saturates at its top value.
    for (int k = 0; k < 257; k++) issue(OP_SENT, 10'd3, 32'(k), ST_IDLE);
    issue(OP_TIMEOUT, 10'd0, 32'd0, ST_IDLE);

    // Random phases, each under its own register setting and one of three idling patterns.
    for (int p = 0; p < 6; p++) begin
      configure(phase_total[p], phase_win[p], phase_tmo[p], phase_att[p]);
      idle_pct = (p < 2) ? 28 : (p < 4) ? 78 : 0;
      issue(OP_RESTART, 10'd0, clock_ms, ST_IDLE);
      for (int k = 0; k < 20; k++) begin
        if (k == 10) drain();
        random_item();
      end
    end

    // Wait for every outstanding result item, then a short settling tail.
    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d items and %0d result items over six register settings.",
             items_seen, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("selective_repeat_send_window verification clean");
    end else begin
      $display("selective_repeat_send_window verification failed");
    end
    $finish;
  end

endmodule
